// ===== rtl/core/dnd_pkg.sv =====
// Shared types, constants and calendar helpers for the day number to date core.
// Used by dnd_ctrl, dnd_dp, the top level and the checker. No dependencies.
package dnd_pkg;

   localparam int SERIAL_W   = 17;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_OUT_W = 12;
   localparam int YEAR_W     = 13;
   localparam int YDAYS_W    = 9;
   localparam int MOD400_W   = 9;

   localparam logic [YDAYS_W-1:0]  DAYS_COMMON_YEAR = 9'd365;
   localparam logic [YDAYS_W-1:0]  DAYS_LEAP_YEAR   = 9'd366;
   localparam logic [MOD400_W-1:0] CENTURY_1        = 9'd100;
   localparam logic [MOD400_W-1:0] CENTURY_2        = 9'd200;
   localparam logic [MOD400_W-1:0] CENTURY_3        = 9'd300;
   localparam logic [MOD400_W-1:0] CYCLE_LAST       = 9'd399;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_YEARS,
      ST_MONTHS
   } state_type;

   typedef struct packed {
      logic load;
      logic year_step;
      logic month_step;
      logic finish_ok;
      logic finish_oor;
   } cmd_type;

   typedef struct packed {
      logic zero;
      logic span_done;
      logic year_more;
      logic month_more;
   } sts_type;

   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
      logic [DAY_W-1:0] days;
      case (month)
         MONTH_FEB: days = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ===== rtl/core/dnd_ctrl.sv =====
// Sequencer for the day number to date core: year phase, month phase, finish.
// Depends on dnd_pkg for the state, command and status types.
module dnd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dnd_pkg::sts_type sts,
   output logic             busy,
   output dnd_pkg::cmd_type cmd
);
   import dnd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_YEARS;
            end
         end
         ST_YEARS: begin
            if (sts.zero || sts.span_done) begin
               cmd.finish_oor = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.year_more) begin
               cmd.year_step = 1'b1;
            end else begin
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            if (sts.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               cmd.finish_ok = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/dnd_dp.sv =====
// Datapath for the day number to date core: remainder, year, month and result words.
// Depends on dnd_pkg; driven by commands from dnd_ctrl.
module dnd_dp #(
   parameter int YEAR_SPAN = 256,
   parameter int BASE_YEAR = 1900
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dnd_pkg::cmd_type                  cmd,
   input  logic [dnd_pkg::SERIAL_W-1:0]      req_serial_day,
   output dnd_pkg::sts_type                  sts,
   output logic                              rsp_valid,
   output logic [dnd_pkg::DAY_W-1:0]         rsp_day_of_month,
   output logic [dnd_pkg::MONTH_W-1:0]       rsp_month_num,
   output logic [dnd_pkg::YEAR_OUT_W-1:0]    rsp_year_num,
   output logic                              rsp_out_of_range
);
   import dnd_pkg::*;

   localparam int CNT_W = $clog2(YEAR_SPAN + 1);
   localparam logic [MOD400_W-1:0] BASE_MOD400 = MOD400_W'(BASE_YEAR % 400);
   localparam logic [YEAR_W-1:0]   BASE_YR     = YEAR_W'(BASE_YEAR);
   localparam logic [CNT_W-1:0]    SPAN_CNT    = CNT_W'(YEAR_SPAN);

   logic [SERIAL_W-1:0] rest_ff, rest_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [MOD400_W-1:0] mod400_ff, mod400_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [MONTH_W-1:0]  month_ff, month_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]      rsp_day_ff, rsp_day_in;
   logic [MONTH_W-1:0]    rsp_month_ff, rsp_month_in;
   logic [YEAR_OUT_W-1:0] rsp_year_ff, rsp_year_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic               leap;
   logic [YDAYS_W-1:0] year_days;
   logic [DAY_W-1:0]   month_days;

   always_comb begin
      leap = (year_ff[1:0] == 2'd0) && (mod400_ff != CENTURY_1) &&
             (mod400_ff != CENTURY_2) && (mod400_ff != CENTURY_3);
      year_days  = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
      month_days = days_in_month(month_ff, leap);

      sts.zero       = (rest_ff == '0);
      sts.span_done  = (count_ff >= SPAN_CNT);
      sts.year_more  = (rest_ff > SERIAL_W'(year_days));
      sts.month_more = (month_ff < MONTH_DEC) && (rest_ff > SERIAL_W'(month_days));
   end

   always_comb begin
      rest_in   = rest_ff;
      year_in   = year_ff;
      mod400_in = mod400_ff;
      count_in  = count_ff;
      month_in  = month_ff;
      if (cmd.load) begin
         rest_in   = req_serial_day;
         year_in   = BASE_YR;
         mod400_in = BASE_MOD400;
         count_in  = '0;
         month_in  = MONTH_JAN;
      end else if (cmd.year_step) begin
         rest_in   = rest_ff - SERIAL_W'(year_days);
         year_in   = year_ff + YEAR_W'(1);
         mod400_in = (mod400_ff == CYCLE_LAST) ? '0 : mod400_ff + MOD400_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end else if (cmd.month_step) begin
         rest_in  = rest_ff - SERIAL_W'(month_days);
         month_in = month_ff + MONTH_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = cmd.finish_ok || cmd.finish_oor;
      rsp_day_in   = '0;
      rsp_month_in = '0;
      rsp_year_in  = '0;
      rsp_oor_in   = 1'b1;
      if (cmd.finish_ok) begin
         rsp_day_in   = rest_ff[DAY_W-1:0];
         rsp_month_in = month_ff;
         rsp_year_in  = year_ff[YEAR_OUT_W-1:0];
         rsp_oor_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff   <= rest_in;
      year_ff   <= year_in;
      mod400_ff <= mod400_in;
      count_ff  <= count_in;
      month_ff  <= month_in;
      if (rsp_valid_in) begin
         rsp_day_ff   <= rsp_day_in;
         rsp_month_ff <= rsp_month_in;
         rsp_year_ff  <= rsp_year_in;
         rsp_oor_ff   <= rsp_oor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_day_of_month = rsp_day_ff;
   assign rsp_month_num    = rsp_month_ff;
   assign rsp_year_num     = rsp_year_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

// ===== rtl/core/day_number_to_date_core.sv =====
// Top level of the serial day number to Gregorian date converter.
// Instantiates dnd_ctrl and dnd_dp; depends on dnd_pkg.
//
// A word is taken when start is high while busy is low. The converter then
// removes one year length per cycle from the day number (up to YEAR_SPAN
// years), then one month length per cycle (up to eleven). It shows the result
// in the cycle in which busy drops, with rsp_valid high for that single cycle.
// The result must be captured then, as it cannot be held off. Day zero and
// day numbers beyond the span both set out_of_range and give zero date fields.
// A new word may be started in the cycle that shows the previous result.
module day_number_to_date_core #(
   parameter int YEAR_SPAN = 256,
   parameter int BASE_YEAR = 1900
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dnd_pkg::SERIAL_W-1:0]      req_serial_day,
   output logic                              rsp_valid,
   output logic [dnd_pkg::DAY_W-1:0]         rsp_day_of_month,
   output logic [dnd_pkg::MONTH_W-1:0]       rsp_month_num,
   output logic [dnd_pkg::YEAR_OUT_W-1:0]    rsp_year_num,
   output logic                              rsp_out_of_range
);
   import dnd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dnd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   dnd_dp #(
      .YEAR_SPAN (YEAR_SPAN),
      .BASE_YEAR (BASE_YEAR)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_serial_day   (req_serial_day),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_month_num    (rsp_month_num),
      .rsp_year_num     (rsp_year_num),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// ===== rtl/core/dnd_checker.sv =====
// Port-level checks for day_number_to_date_core, bound to the top level.
// Depends on dnd_pkg for field widths and month codes.
module dnd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [dnd_pkg::SERIAL_W-1:0]      req_serial_day,
   input logic                              rsp_valid,
   input logic [dnd_pkg::DAY_W-1:0]         rsp_day_of_month,
   input logic [dnd_pkg::MONTH_W-1:0]       rsp_month_num,
   input logic [dnd_pkg::YEAR_OUT_W-1:0]    rsp_year_num,
   input logic                              rsp_out_of_range
);
   import dnd_pkg::*;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_day_of_month == '0 && rsp_month_num == '0 && rsp_year_num == '0)
      else $error("out-of-range word carries nonzero date");

   a_date_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |->
         rsp_month_num >= MONTH_JAN && rsp_month_num <= MONTH_DEC &&
         rsp_day_of_month != '0)
      else $error("in-range word carries illegal month or day");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result word");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while busy");

endmodule

bind day_number_to_date_core dnd_checker u_dnd_checker (.*);

// ===== tb/tb_day_number_to_date_core.sv =====
// Self-checking testbench for day_number_to_date_core: serial day numbers in,
// calendar dates out, checked against an in-bench calendar predictor.
// Depends on dnd_pkg and the day_number_to_date_core RTL.
`timescale 1ns / 100ps

module tb_day_number_to_date_core;
   import dnd_pkg::*;

   localparam int YEAR_SPAN       = 256;
   localparam int BASE_YEAR       = 1900;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_ITEMS    = 545;

   typedef struct packed {
      logic [DAY_W-1:0]      day;
      logic [MONTH_W-1:0]    month;
      logic [YEAR_OUT_W-1:0] year;
      logic                  oor;
   } date_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [SERIAL_W-1:0]   req_serial_day = '0;
   logic                  rsp_valid;
   logic [DAY_W-1:0]      rsp_day_of_month;
   logic [MONTH_W-1:0]    rsp_month_num;
   logic [YEAR_OUT_W-1:0] rsp_year_num;
   logic                  rsp_out_of_range;

   date_word_type pending_dates[$];
   int         sender_idle_pct = 0;
   int         items_sent      = 0;
   int         dates_checked   = 0;
   int         oor_seen        = 0;
   int         error_count     = 0;
   int         idle_cycles     = 0;
   int         last_valid_day;

   day_number_to_date_core #(
      .YEAR_SPAN (YEAR_SPAN),
      .BASE_YEAR (BASE_YEAR)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_serial_day   (req_serial_day),
      .rsp_valid        (rsp_valid),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_month_num    (rsp_month_num),
      .rsp_year_num     (rsp_year_num),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always #5 clock = ~clock;

   function automatic bit leap_check(input int year);
      return (year % 4 == 0) && !((year % 100 == 0) && (year % 400 != 0));
   endfunction

   function automatic int days_of_year(input int year);
      return leap_check(year) ? 366 : 365;
   endfunction

   function automatic int days_of_month(input int month, input bit leap);
      if (month == MONTH_FEB)
         return leap ? 29 : 28;
      if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
          month == MONTH_NOV)
         return 30;
      return 31;
   endfunction

   function automatic int serial_for(input int year, input int month, input int day);
      int total;
      total = day;
      for (int y = BASE_YEAR; y < year; y++)
         total += days_of_year(y);
      for (int m = int'(MONTH_JAN); m < month; m++)
         total += days_of_month(m, leap_check(year));
      return total;
   endfunction

   function automatic date_word_type convert_day(input logic [SERIAL_W-1:0] serial);
      date_word_type word;
      int         rest;
      int         year;
      int         month;
      int         years_taken;
      word        = '0;
      rest        = int'(serial);
      year        = BASE_YEAR;
      month       = int'(MONTH_JAN);
      years_taken = 0;
      if (rest == 0) begin
         word.oor = 1'b1;
         return word;
      end
      while (years_taken < YEAR_SPAN && rest > days_of_year(year)) begin
         rest -= days_of_year(year);
         year++;
         years_taken++;
      end
      if (years_taken >= YEAR_SPAN) begin
         word.oor = 1'b1;
         return word;
      end
      while (month < MONTH_DEC && rest > days_of_month(month, leap_check(year))) begin
         rest -= days_of_month(month, leap_check(year));
         month++;
      end
      word.day   = rest[DAY_W-1:0];
      word.month = month[MONTH_W-1:0];
      word.year  = year[YEAR_OUT_W-1:0];
      return word;
   endfunction

   function automatic void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      end
   endfunction

   always @(posedge clock) begin
      date_word_type expected;
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, actual %0d-%0d-%0d oor %0b", $time,
                     rsp_year_num, rsp_month_num, rsp_day_of_month, rsp_out_of_range);
         end else begin
            expected = pending_dates.pop_front();
            check_field("day_of_month", int'(expected.day), int'(rsp_day_of_month));
            check_field("month_num", int'(expected.month), int'(rsp_month_num));
            check_field("year_num", int'(expected.year), int'(rsp_year_num));
            check_field("out_of_range", int'(expected.oor), int'(rsp_out_of_range));
            dates_checked++;
            if (rsp_out_of_range)
               oor_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: watchdog expired with %0d words outstanding", $time,
                  pending_dates.size());
         $display("tb_day_number_to_date_core: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_day(input int serial);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         if ($urandom_range(99) < sender_idle_pct) begin
            start          <= 1'b0;
            req_serial_day <= SERIAL_W'($urandom_range(2**SERIAL_W - 1));
         end else begin
            start          <= 1'b1;
            req_serial_day <= serial[SERIAL_W-1:0];
         end
         @(posedge clock);
         taken = (start === 1'b1) && (busy === 1'b0);
      end
      pending_dates.push_back(convert_day(serial[SERIAL_W-1:0]));
      items_sent++;
   endtask

   task automatic test_calendar_edges();
      send_day(1);
      send_day(serial_for(1900, 2, 28));
      send_day(serial_for(1900, 3, 1));
      send_day(serial_for(1904, 2, 29));
      send_day(serial_for(2000, 2, 29));
      send_day(serial_for(2100, 3, 1));
   endtask

   task automatic test_month_ends();
      for (int m = int'(MONTH_JAN); m <= MONTH_DEC; m++)
         send_day(serial_for(2023, m, days_of_month(m, leap_check(2023))));
   endtask

   task automatic test_span_limits();
      send_day(0);
      send_day(last_valid_day);
      send_day(last_valid_day + 1);
      send_day(2**SERIAL_W - 1);
   endtask

   task automatic test_random_dates(input int idle_pct, input int count);
      int pick;
      int year;
      int month;
      int day;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         pick  = $urandom_range(99);
         year  = BASE_YEAR + $urandom_range(YEAR_SPAN - 1);
         month = $urandom_range(MONTH_JAN, MONTH_DEC);
         if (pick < 60) begin
            day = $urandom_range(1, days_of_month(month, leap_check(year)));
            send_day(serial_for(year, month, day));
         end else if (pick < 78) begin
            day = $urandom_range(1) ? 1 : days_of_month(month, leap_check(year));
            send_day(serial_for(year, month, day));
         end else if (pick < 88) begin
            send_day($urandom_range(last_valid_day + 1, 2**SERIAL_W - 1));
         end else if (pick < 91) begin
            send_day(0);
         end else begin
            send_day($urandom_range(2**SERIAL_W - 1));
         end
      end
   endtask

   initial begin
      last_valid_day = serial_for(BASE_YEAR + YEAR_SPAN - 1, MONTH_DEC, 31);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_calendar_edges();
      test_month_ends();
      test_span_limits();
      test_random_dates(34, RANDOM_ITEMS);
      test_random_dates(80, RANDOM_ITEMS);
      test_random_dates(0, RANDOM_ITEMS);
      start <= 1'b0;
      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d day numbers, %0d dates checked, %0d out of range.",
               items_sent, dates_checked, oor_seen);
      $display("Sender idle mixes 34/80/0 percent, %0d mismatches.", error_count);
      if (error_count == 0 && pending_dates.size() == 0)
         $display("tb_day_number_to_date_core: done, clean");
      else
         $display("tb_day_number_to_date_core: done, errors");
      $finish;
   end

endmodule
